// ----- design/brc_pkg.sv -----
`timescale 1ns / 1ps

package brc_pkg;

  localparam int WORD_BITS       = 64;
  localparam int DEF_STORE_WORDS = 64;

  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 6;
  localparam int OFF_W   = 12;
  localparam int CNT_W   = 13;
  // Bit positions and sums of offset plus count: 4095 + 8191 fits 14 bits.
  localparam int POS_W   = 14;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WIDX_W  = POS_W - BIT_W;

  localparam logic [FUNC_W-1:0] FUNC_WR_SRC = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_DST = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_DST = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_COPY   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  typedef struct packed {
    logic [BIT_W-1:0] shift;
    logic             invert;
    logic [BIT_W-1:0] lo_bit;
    logic [BIT_W-1:0] hi_bit;
  } merge_ctl_t;

endpackage

// ----- design/brc_ifs.sv -----
`timescale 1ns / 1ps

interface brc_in_if import brc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [INDEX_W-1:0]   word_index;
  logic [WORD_BITS-1:0] word_data;
  logic [OFF_W-1:0]     src_offset;
  logic [OFF_W-1:0]     dst_offset;
  logic [CNT_W-1:0]     bit_count;
  logic                 invert_bits;

  modport source (
    output valid, func, word_index, word_data, src_offset, dst_offset, bit_count,
           invert_bits,
    input  ready
  );
  modport sink (
    input  valid, func, word_index, word_data, src_offset, dst_offset, bit_count,
           invert_bits,
    output ready
  );
endinterface

interface brc_out_if import brc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] read_word;
  logic                 any_one_copied;
  logic                 may_have_nulls;
  logic                 range_error;

  modport source (
    output valid, read_word, any_one_copied, may_have_nulls, range_error,
    input  ready
  );
  modport sink (
    input  valid, read_word, any_one_copied, may_have_nulls, range_error,
    output ready
  );
endinterface

// ----- design/bitmap_range_copy_unit.sv -----
`timescale 1ns / 1ps

// Bit-field copy engine over two word stores (source and destination bitmaps).
// Each transaction yields exactly one result. Word writes and the clear/unused
// commands produce their result in the cycle after acceptance; a destination read
// passes through the registered memory read first. A copy runs a range-check
// state, then one destination word per cycle through a read / funnel-shift /
// merge / write-back pipeline on the memory ports, for each of the N destination
// words the range touches (at most STORE_WORDS, 64 for a full-store copy), then a
// drain state. A rejected or empty copy ends after the range check. The next
// command is accepted once the unit is idle and the result register is free or
// being taken. Store contents are undefined until written; there is no clearing
// pass.

module bitmap_range_copy_unit import brc_pkg::*; #(
  parameter int STORE_WORDS = DEF_STORE_WORDS
) (
  input logic       clk,
  input logic       rst_n,
  brc_in_if.sink    in_chan,
  brc_out_if.source out_chan
);

  localparam int AW         = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int TOTAL_BITS = STORE_WORDS * WORD_BITS;
  localparam int SW_W       = WIDX_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [WORD_BITS-1:0] src_mem [STORE_WORDS];
  logic [WORD_BITS-1:0] dst_mem [STORE_WORDS];

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       sticky_r, sticky_nxt;
  logic       p_valid_r, p_valid_nxt;

  logic [WORD_BITS-1:0] out_word_r;
  logic                 out_any_r;
  logic                 out_mhn_r;
  logic                 out_err_r;

  logic                 out_load;
  logic [WORD_BITS-1:0] out_word_nxt;
  logic                 out_any_nxt;
  logic                 out_mhn_nxt;
  logic                 out_err_nxt;

  // Copy command fields
  logic [OFF_W-1:0] soff_r;
  logic [OFF_W-1:0] doff_r;
  logic [CNT_W-1:0] cnt_r;
  logic             inv_r;

  // Per-copy walk state
  logic [WIDX_W-1:0]        first_w_r;
  logic [WIDX_W-1:0]        last_w_r;
  logic [BIT_W-1:0]         lo_bit_r;
  logic [BIT_W-1:0]         hi_bit_r;
  logic [BIT_W-1:0]         sh_r;
  logic signed [WIDX_W-1:0] dq_r;
  logic [WIDX_W-1:0]        d_r;
  logic [WIDX_W-1:0]        p_d_r;
  logic                     any_acc_r;

  logic [WORD_BITS-1:0] src_lo_r;
  logic [WORD_BITS-1:0] src_hi_r;
  logic [WORD_BITS-1:0] dst_rd_r;

  logic in_fire, out_fire, idx_ok;

  logic [POS_W-1:0]         s_end, d_end, d_last;
  logic signed [POS_W-1:0]  delta;
  logic                     chk_err;

  logic signed [SW_W-1:0]   sw0, sw1;
  logic                     ok0, ok1;

  logic                 dst_re;
  logic [AW-1:0]        dst_ra;
  logic                 dst_we;
  logic [AW-1:0]        dst_wa;
  logic [WORD_BITS-1:0] dst_wd;

  merge_ctl_t           mctl;
  logic [WORD_BITS-1:0] merged;
  logic                 word_any;
  logic                 any_fin;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign idx_ok   = int'(in_chan.word_index) < STORE_WORDS;

  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);

  assign out_chan.valid          = out_valid_r;
  assign out_chan.read_word      = out_word_r;
  assign out_chan.any_one_copied = out_any_r;
  assign out_chan.may_have_nulls = out_mhn_r;
  assign out_chan.range_error    = out_err_r;

  // Range check on the latched copy command
  always_comb begin
    s_end   = POS_W'(soff_r) + POS_W'(cnt_r);
    d_end   = POS_W'(doff_r) + POS_W'(cnt_r);
    d_last  = d_end - POS_W'(1);
    delta   = signed'(POS_W'(soff_r) - POS_W'(doff_r));
    chk_err = (int'(s_end) > TOTAL_BITS) || (int'(d_end) > TOTAL_BITS);
  end

  // Source words under the destination word being issued
  always_comb begin
    sw0 = signed'({2'b00, d_r}) + SW_W'(dq_r);
    sw1 = sw0 + SW_W'(1);
    ok0 = !sw0[SW_W-1] && (int'(sw0) < STORE_WORDS);
    ok1 = !sw1[SW_W-1] && (int'(sw1) < STORE_WORDS);
  end

  always_comb begin
    mctl.shift  = sh_r;
    mctl.invert = inv_r;
    mctl.lo_bit = (p_d_r == first_w_r) ? lo_bit_r : '0;
    mctl.hi_bit = (p_d_r == last_w_r) ? hi_bit_r : BIT_W'(WORD_BITS - 1);
  end

  brc_word_merge u_merge (
    .src_lo   (src_lo_r),
    .src_hi   (src_hi_r),
    .dst_word (dst_rd_r),
    .ctl      (mctl),
    .merged   (merged),
    .any_one  (word_any)
  );

  assign any_fin = any_acc_r | word_any;

  // Destination memory port selection
  always_comb begin
    dst_re = 1'b0;
    dst_ra = AW'(in_chan.word_index);
    if (state_r == S_RUN) begin
      dst_re = 1'b1;
      dst_ra = AW'(d_r);
    end else if (in_fire && in_chan.func == FUNC_RD_DST && idx_ok) begin
      dst_re = 1'b1;
    end

    dst_we = 1'b0;
    dst_wa = AW'(in_chan.word_index);
    dst_wd = in_chan.word_data;
    if (p_valid_r) begin
      dst_we = 1'b1;
      dst_wa = AW'(p_d_r);
      dst_wd = merged;
    end else if (in_fire && in_chan.func == FUNC_WR_DST && idx_ok) begin
      dst_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sticky_nxt    = sticky_r;
    p_valid_nxt   = 1'b0;
    out_load      = 1'b0;
    out_word_nxt  = '0;
    out_any_nxt   = 1'b0;
    out_mhn_nxt   = sticky_r;
    out_err_nxt   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.func)
            FUNC_WR_SRC, FUNC_WR_DST: begin
              out_load    = 1'b1;
              out_err_nxt = !idx_ok;
            end
            FUNC_RD_DST: begin
              if (idx_ok) begin
                state_nxt = S_READ;
              end else begin
                out_load    = 1'b1;
                out_err_nxt = 1'b1;
              end
            end
            FUNC_COPY: begin
              state_nxt = S_CHECK;
            end
            FUNC_CLEAR: begin
              sticky_nxt  = 1'b0;
              out_load    = 1'b1;
              out_mhn_nxt = 1'b0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_load     = 1'b1;
        out_word_nxt = dst_rd_r;
        state_nxt    = S_IDLE;
      end
      S_CHECK: begin
        if (chk_err || cnt_r == '0) begin
          out_load    = 1'b1;
          out_err_nxt = chk_err;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        p_valid_nxt = 1'b1;
        if (d_r == last_w_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        out_load    = 1'b1;
        out_any_nxt = any_fin;
        out_mhn_nxt = sticky_r | any_fin;
        sticky_nxt  = sticky_r | any_fin;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sticky_r    <= 1'b0;
      p_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sticky_r    <= sticky_nxt;
      p_valid_r   <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= out_word_nxt;
      out_any_r  <= out_any_nxt;
      out_mhn_r  <= out_mhn_nxt;
      out_err_r  <= out_err_nxt;
    end

    if (in_fire && in_chan.func == FUNC_COPY) begin
      soff_r <= in_chan.src_offset;
      doff_r <= in_chan.dst_offset;
      cnt_r  <= in_chan.bit_count;
      inv_r  <= in_chan.invert_bits;
    end

    if (state_r == S_CHECK) begin
      first_w_r <= WIDX_W'(doff_r[OFF_W-1:BIT_W]);
      last_w_r  <= d_last[POS_W-1:BIT_W];
      lo_bit_r  <= doff_r[BIT_W-1:0];
      hi_bit_r  <= d_last[BIT_W-1:0];
      sh_r      <= delta[BIT_W-1:0];
      dq_r      <= delta[POS_W-1:BIT_W];
      d_r       <= WIDX_W'(doff_r[OFF_W-1:BIT_W]);
      any_acc_r <= 1'b0;
    end else begin
      if (state_r == S_RUN) begin
        d_r <= d_r + WIDX_W'(1);
      end
      if (p_valid_r) begin
        any_acc_r <= any_acc_r | word_any;
      end
    end

    if (state_r == S_RUN) begin
      p_d_r <= d_r;
    end
  end

  // Source store: word writes from the input, two reads per copy step
  always_ff @(posedge clk) begin
    if (in_fire && in_chan.func == FUNC_WR_SRC && idx_ok) begin
      src_mem[AW'(in_chan.word_index)] <= in_chan.word_data;
    end
    if (state_r == S_RUN) begin
      src_lo_r <= ok0 ? src_mem[AW'(sw0)] : '0;
      src_hi_r <= ok1 ? src_mem[AW'(sw1)] : '0;
    end
  end

  // Destination store: one write, one read per cycle
  always_ff @(posedge clk) begin
    if (dst_we) begin
      dst_mem[dst_wa] <= dst_wd;
    end
    if (dst_re) begin
      dst_rd_r <= dst_mem[dst_ra];
    end
  end

endmodule

// ----- design/brc_word_merge.sv -----
`timescale 1ns / 1ps

module brc_word_merge import brc_pkg::*; (
  input  logic [WORD_BITS-1:0] src_lo,
  input  logic [WORD_BITS-1:0] src_hi,
  input  logic [WORD_BITS-1:0] dst_word,
  input  merge_ctl_t           ctl,
  output logic [WORD_BITS-1:0] merged,
  output logic                 any_one
);

  logic [2*WORD_BITS-1:0] pair;
  logic [WORD_BITS-1:0]   bits;
  logic [WORD_BITS-1:0]   mask;

  always_comb begin
    // Funnel the two source words down to the destination word's alignment.
    pair   = {src_hi, src_lo} >> ctl.shift;
    bits   = pair[WORD_BITS-1:0] ^ {WORD_BITS{ctl.invert}};
    mask   = ({WORD_BITS{1'b1}} << ctl.lo_bit) &
             ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - ctl.hi_bit));
    merged = (dst_word & ~mask) | (bits & mask);
    any_one = |(bits & mask);
  end

endmodule

// ----- bench/bitmap_range_copy_unit_tb.sv -----
`timescale 1ns / 1ps

module bitmap_range_copy_unit_tb;
  import brc_pkg::*;

  localparam int STORE_WORDS = DEF_STORE_WORDS;
  localparam int TOTAL_BITS  = STORE_WORDS * WORD_BITS;
  localparam int MAX_OFFSET  = (1 << OFF_W) - 1;
  localparam int MAX_COUNT   = (1 << CNT_W) - 1;
  localparam int RANDOM_CMDS = 600;
  localparam int QUIET_TAIL  = 100;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DIR_ROWS    = 25;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [INDEX_W-1:0]   word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [OFF_W-1:0]     src_offset;
    logic [OFF_W-1:0]     dst_offset;
    logic [CNT_W-1:0]     bit_count;
    logic                 invert_bits;
  } bitop_cmd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_word;
    logic                 any_one_copied;
    logic                 may_have_nulls;
    logic                 range_error;
  } bitop_res_t;

  typedef struct packed {
    bitop_cmd_t cmd;
    logic       typed;
    bitop_res_t res;
  } dir_row_t;

  localparam bitop_res_t RES_IDLE   = '0;
  localparam bitop_res_t RES_REJECT = '{read_word: '0, any_one_copied: 1'b0,
                                        may_have_nulls: 1'b0, range_error: 1'b1};

  logic clk;
  logic rst_n;

  brc_in_if  in_if ();
  brc_out_if out_if ();

  bitmap_range_copy_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow of the block state
  logic [WORD_BITS-1:0] src_words [STORE_WORDS];
  logic [WORD_BITS-1:0] dst_words [STORE_WORDS];
  logic                 sticky_nulls = 1'b0;

  bitop_res_t pending_results [$];

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;

  int error_cnt    = 0;
  int cmds_sent    = 0;
  int copies_sent  = 0;
  int copy_rejects = 0;
  int results_seen = 0;
  int cycle_cnt    = 0;

  // Rows that need no predictor carry their result; the rest are predicted.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{FUNC_CLEAR, 6'd0, '0, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b1, RES_IDLE},
    '{'{FUNC_UNUSED_5, '1, '1, '1, '1, '1, 1'b1}, 1'b1, RES_IDLE},
    '{'{FUNC_UNUSED_6, 6'd5, 64'h0123_4567_89ab_cdef, 12'd7, 12'd9, 13'd11, 1'b0},
      1'b1, RES_IDLE},
    '{'{FUNC_UNUSED_7, '0, '0, '0, '0, '0, 1'b0}, 1'b1, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd4095, 12'd0, 13'd2, 1'b0}, 1'b1, RES_REJECT},
    '{'{FUNC_COPY, 6'd0, '0, 12'd0, 12'd4095, 13'd2, 1'b1}, 1'b1, RES_REJECT},
    '{'{FUNC_COPY, 6'd0, '0, 12'd1, 12'd0, 13'd4096, 1'b0}, 1'b1, RES_REJECT},
    '{'{FUNC_COPY, 6'd0, '0, 12'd4095, 12'd4095, 13'd8191, 1'b1}, 1'b1, RES_REJECT},
    '{'{FUNC_COPY, 6'd0, '0, 12'd0, 12'd0, 13'd4097, 1'b0}, 1'b1, RES_REJECT},
    '{'{FUNC_COPY, 6'd0, '0, 12'd4095, 12'd4095, 13'd0, 1'b1}, 1'b1, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd64, 12'd300, 13'd128, 1'b0}, 1'b0, RES_IDLE},
    '{'{FUNC_WR_SRC, 6'd63, '1, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b1, RES_IDLE},
    '{'{FUNC_WR_DST, 6'd0, '0, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b1, RES_IDLE},
    '{'{FUNC_RD_DST, 6'd0, '0, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b1, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd0, 12'd0, 13'd4096, 1'b0}, 1'b0, RES_IDLE},
    '{'{FUNC_RD_DST, 6'd63, '0, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b0, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd4095, 12'd4095, 13'd1, 1'b1}, 1'b0, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd4095, 12'd0, 13'd1, 1'b0}, 1'b0, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd0, 12'd4095, 13'd1, 1'b1}, 1'b0, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd3, 12'd70, 13'd200, 1'b1}, 1'b0, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd8, 12'd16, 13'd64, 1'b0}, 1'b0, RES_IDLE},
    '{'{FUNC_CLEAR, 6'd0, '0, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b1, RES_IDLE},
    '{'{FUNC_COPY, 6'd0, '0, 12'd0, 12'd0, 13'd4096, 1'b1}, 1'b0, RES_IDLE},
    '{'{FUNC_RD_DST, 6'd31, '0, 12'd0, 12'd0, 13'd0, 1'b0}, 1'b0, RES_IDLE},
    '{'{FUNC_WR_DST, 6'd63, 64'h8000_0000_0000_0001, 12'd0, 12'd0, 13'd0, 1'b0},
      1'b0, RES_IDLE}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow state and return its result.
  function automatic bitop_res_t bitcopy_predict(bitop_cmd_t c);
    bitop_res_t r;
    int         sp;
    int         dp;
    logic       b;
    r = '0;
    case (c.func)
      FUNC_WR_SRC: src_words[c.word_index] = c.word_data;
      FUNC_WR_DST: dst_words[c.word_index] = c.word_data;
      FUNC_RD_DST: r.read_word = dst_words[c.word_index];
      FUNC_COPY: begin
        if (int'(c.src_offset) + int'(c.bit_count) > TOTAL_BITS ||
            int'(c.dst_offset) + int'(c.bit_count) > TOTAL_BITS) begin
          r.range_error = 1'b1;
        end else begin
          for (int i = 0; i < int'(c.bit_count); i++) begin
            sp = int'(c.src_offset) + i;
            dp = int'(c.dst_offset) + i;
            b  = src_words[sp / WORD_BITS][sp % WORD_BITS] ^ c.invert_bits;
            dst_words[dp / WORD_BITS][dp % WORD_BITS] = b;
            r.any_one_copied |= b;
          end
          if (r.any_one_copied) sticky_nulls = 1'b1;
        end
      end
      FUNC_CLEAR: sticky_nulls = 1'b0;
      default: ;
    endcase
    r.may_have_nulls = sticky_nulls;
    return r;
  endfunction

  function automatic bitop_cmd_t random_bitop();
    bitop_cmd_t  c;
    int unsigned sel;
    int unsigned cnt;
    c.func        = FUNC_COPY;
    c.word_index  = INDEX_W'($urandom_range(0, STORE_WORDS - 1));
    c.word_data   = {$urandom, $urandom};
    c.src_offset  = OFF_W'($urandom_range(0, MAX_OFFSET));
    c.dst_offset  = OFF_W'($urandom_range(0, MAX_OFFSET));
    c.bit_count   = CNT_W'($urandom_range(0, MAX_COUNT));
    c.invert_bits = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 40 || sel >= 96) begin
      // well-formed copy, mostly short, a few spanning half or more of the store
      if (sel >= 96) cnt = $urandom_range(TOTAL_BITS / 2, TOTAL_BITS);
      else if ($urandom_range(0, 9) < 7) cnt = $urandom_range(1, 130);
      else cnt = $urandom_range(1, 1024);
      c.bit_count  = CNT_W'(cnt);
      c.src_offset = OFF_W'($urandom_range(0, TOTAL_BITS - cnt));
      c.dst_offset = OFF_W'($urandom_range(0, TOTAL_BITS - cnt));
    end else if (sel < 55) begin
      c.func = FUNC_RD_DST;
    end else if (sel < 65) begin
      c.func = FUNC_WR_SRC;
    end else if (sel < 75) begin
      c.func = FUNC_WR_DST;
    end else if (sel < 80) begin
      c.func = FUNC_CLEAR;
    end else if (sel < 83) begin
      c.func = FUNC_CLEAR + FUNC_W'($urandom_range(1, 3));
    end else if (sel < 92) begin
      // range runs off the end of one store, or the count alone is too big
      case ($urandom_range(0, 2))
        0: begin
          cnt = $urandom_range(2, TOTAL_BITS);
          c.bit_count  = CNT_W'(cnt);
          c.src_offset = OFF_W'($urandom_range(TOTAL_BITS + 1 - cnt, MAX_OFFSET));
          c.dst_offset = OFF_W'($urandom_range(0, TOTAL_BITS - cnt));
        end
        1: begin
          cnt = $urandom_range(2, TOTAL_BITS);
          c.bit_count  = CNT_W'(cnt);
          c.src_offset = OFF_W'($urandom_range(0, TOTAL_BITS - cnt));
          c.dst_offset = OFF_W'($urandom_range(TOTAL_BITS + 1 - cnt, MAX_OFFSET));
        end
        default: c.bit_count = CNT_W'($urandom_range(TOTAL_BITS + 1, MAX_COUNT));
      endcase
    end else begin
      c.bit_count = '0;
    end
    return c;
  endfunction

  task automatic send_cmd(input bitop_cmd_t c, input logic typed, input bitop_res_t typed_res);
    bitop_res_t pred;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= c.func;
    in_if.word_index  <= c.word_index;
    in_if.word_data   <= c.word_data;
    in_if.src_offset  <= c.src_offset;
    in_if.dst_offset  <= c.dst_offset;
    in_if.bit_count   <= c.bit_count;
    in_if.invert_bits <= c.invert_bits;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = bitcopy_predict(c);
    pending_results.push_back(typed ? typed_res : pred);
    cmds_sent++;
    if (c.func == FUNC_COPY) begin
      copies_sent++;
      if (pred.range_error) copy_rejects++;
    end
  endtask

  // Result sink with random stall bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    bitop_res_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with no command pending");
        error_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.read_word !== exp_res.read_word) begin
          $error("read_word: expected %h, got %h", exp_res.read_word, out_if.read_word);
          error_cnt++;
        end
        if (out_if.any_one_copied !== exp_res.any_one_copied) begin
          $error("any_one_copied: expected %b, got %b", exp_res.any_one_copied,
                 out_if.any_one_copied);
          error_cnt++;
        end
        if (out_if.may_have_nulls !== exp_res.may_have_nulls) begin
          $error("may_have_nulls: expected %b, got %b", exp_res.may_have_nulls,
                 out_if.may_have_nulls);
          error_cnt++;
        end
        if (out_if.range_error !== exp_res.range_error) begin
          $error("range_error: expected %b, got %b", exp_res.range_error,
                 out_if.range_error);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    bitop_cmd_t c;
    logic [1:0] mode;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= '0;
    in_if.word_index  <= '0;
    in_if.word_data   <= '0;
    in_if.src_offset  <= '0;
    in_if.dst_offset  <= '0;
    in_if.bit_count   <= '0;
    in_if.invert_bits <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Load every word of both stores so no copy or read touches unwritten data.
    // Source words 1 and 2 stay zero for a copy that writes no ones.
    for (int i = 0; i < STORE_WORDS; i++) begin
      c = random_bitop();
      c.func = FUNC_WR_SRC;
      c.word_index = INDEX_W'(i);
      if (i == 0) c.word_data = '1;
      else if (i == 1 || i == 2) c.word_data = '0;
      send_cmd(c, 1'b0, RES_IDLE);
      c.func = FUNC_WR_DST;
      c.word_data = {$urandom, $urandom};
      send_cmd(c, 1'b0, RES_IDLE);
    end

    for (int i = 0; i < DIR_ROWS; i++)
      send_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].res);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // reshuffle which side idles every so often; none near the end
      if (n >= RANDOM_CMDS - QUIET_TAIL) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else if (n % 64 == 0) begin
        mode = 2'($urandom_range(0, 3));
        src_idle_en  = mode[0];
        sink_idle_en = mode[1];
      end
      send_cmd(random_bitop(), 1'b0, RES_IDLE);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d commands incl. %0d copies (%0d out of range), checked %0d results",
             cmds_sent, copies_sent, copy_rejects, results_seen);
    $display("Covered word I/O, unaligned, inverted and full-store copies, sticky flag, stalls");
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/brc_pkg.sv
design/brc_ifs.sv
design/brc_word_merge.sv
design/bitmap_range_copy_unit.sv
bench/bitmap_range_copy_unit_tb.sv
